// ===== hw/rtl/bdi_pkg.sv =====
// Shared types, codes and the microcode table for the drag integrator.
// No dependencies; every other file of the block but bdi_isqrt uses this package.
`default_nettype none

package bdi_pkg;

   typedef struct packed {
      logic [1:0]         operation;
      logic signed [31:0] start_x;
      logic signed [31:0] start_y;
      logic signed [31:0] start_z;
      logic signed [31:0] dir_x;
      logic signed [31:0] dir_y;
      logic signed [31:0] dir_z;
      logic [15:0]        time_step;
   } req_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic               flying;
      logic               retired;
   } rsp_type;

   localparam logic [1:0] OP_FIRE = 2'd0;
   localparam logic [1:0] OP_TICK = 2'd1;
   localparam logic [1:0] OP_HIT  = 2'd2;

   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_WIND_X    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WIND_Y    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WIND_Z    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GRAV_X    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_GRAV_Y    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_GRAV_Z    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_DRAG      = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_MUZZLE    = 3'd7;

   typedef logic [5:0] step_type;

   localparam step_type S_IDLE = 6'd0;
   localparam step_type S_FIRE = 6'd1;
   localparam step_type S_HIT  = 6'd7;
   localparam step_type S_TICK = 6'd8;
   localparam step_type S_END  = 6'd39;

   typedef enum logic [2:0] {
      MUL_NONE,
      MUL_DIR_MUZ,
      MUL_REL_SQ,
      MUL_K_MAG,
      MUL_C_REL,
      MUL_ACC_HI,
      MUL_ACC_LO,
      MUL_V_DT
   } mul_op_type;

   typedef enum logic [1:0] {
      AX_X,
      AX_Y,
      AX_Z
   } axis_type;

   typedef enum logic [3:0] {
      WB_NONE,
      WB_FIRE_POS,
      WB_FIRE_VEL,
      WB_HIT,
      WB_REL_ALL,
      WB_SUMSQ_ADD,
      WB_SQRT_START,
      WB_COEF,
      WB_ACC,
      WB_TMP,
      WB_VEL,
      WB_POS,
      WB_RETIRE
   } wb_op_type;

   typedef enum logic [2:0] {
      BR_NEXT,
      BR_JUMP,
      BR_DISPATCH,
      BR_SKIP_IDLE,
      BR_WAIT_SQRT,
      BR_DONE
   } br_type;

   typedef struct packed {
      mul_op_type mul;
      axis_type   ax;
      wb_op_type  wb;
      br_type     br;
      step_type   target;
   } uword_type;

   typedef struct packed {
      uword_type uw;
      logic      load;
      logic      emit;
   } seq_ctl_type;

   typedef struct packed {
      logic flying;
      logic sqrt_busy;
   } dp_stat_type;

   function automatic uword_type bdi_ucode(input step_type step);
      uword_type uw;
      uw = '{MUL_NONE, AX_X, WB_NONE, BR_JUMP, S_IDLE};
      case (step)
         6'd0:  uw = '{MUL_NONE,    AX_X, WB_NONE,       BR_DISPATCH,  S_IDLE};
         6'd1:  uw = '{MUL_DIR_MUZ, AX_X, WB_FIRE_POS,   BR_NEXT,      S_IDLE};
         6'd2:  uw = '{MUL_NONE,    AX_X, WB_FIRE_VEL,   BR_NEXT,      S_IDLE};
         6'd3:  uw = '{MUL_DIR_MUZ, AX_Y, WB_NONE,       BR_NEXT,      S_IDLE};
         6'd4:  uw = '{MUL_NONE,    AX_Y, WB_FIRE_VEL,   BR_NEXT,      S_IDLE};
         6'd5:  uw = '{MUL_DIR_MUZ, AX_Z, WB_NONE,       BR_NEXT,      S_IDLE};
         6'd6:  uw = '{MUL_NONE,    AX_Z, WB_FIRE_VEL,   BR_JUMP,      S_END};
         6'd7:  uw = '{MUL_NONE,    AX_X, WB_HIT,        BR_JUMP,      S_END};
         6'd8:  uw = '{MUL_NONE,    AX_X, WB_REL_ALL,    BR_SKIP_IDLE, S_END};
         6'd9:  uw = '{MUL_REL_SQ,  AX_X, WB_NONE,       BR_NEXT,      S_IDLE};
         6'd10: uw = '{MUL_REL_SQ,  AX_Y, WB_SUMSQ_ADD,  BR_NEXT,      S_IDLE};
         6'd11: uw = '{MUL_REL_SQ,  AX_Z, WB_SUMSQ_ADD,  BR_NEXT,      S_IDLE};
         6'd12: uw = '{MUL_NONE,    AX_X, WB_SUMSQ_ADD,  BR_NEXT,      S_IDLE};
         6'd13: uw = '{MUL_NONE,    AX_X, WB_SQRT_START, BR_NEXT,      S_IDLE};
         6'd14: uw = '{MUL_NONE,    AX_X, WB_NONE,       BR_WAIT_SQRT, S_IDLE};
         6'd15: uw = '{MUL_K_MAG,   AX_X, WB_NONE,       BR_NEXT,      S_IDLE};
         6'd16: uw = '{MUL_NONE,    AX_X, WB_COEF,       BR_NEXT,      S_IDLE};
         6'd17: uw = '{MUL_C_REL,   AX_X, WB_NONE,       BR_NEXT,      S_IDLE};
         6'd18: uw = '{MUL_NONE,    AX_X, WB_ACC,        BR_NEXT,      S_IDLE};
         6'd19: uw = '{MUL_ACC_HI,  AX_X, WB_NONE,       BR_NEXT,      S_IDLE};
         6'd20: uw = '{MUL_ACC_LO,  AX_X, WB_TMP,        BR_NEXT,      S_IDLE};
         6'd21: uw = '{MUL_NONE,    AX_X, WB_VEL,        BR_NEXT,      S_IDLE};
         6'd22: uw = '{MUL_V_DT,    AX_X, WB_NONE,       BR_NEXT,      S_IDLE};
         6'd23: uw = '{MUL_NONE,    AX_X, WB_POS,        BR_NEXT,      S_IDLE};
         6'd24: uw = '{MUL_C_REL,   AX_Y, WB_NONE,       BR_NEXT,      S_IDLE};
         6'd25: uw = '{MUL_NONE,    AX_Y, WB_ACC,        BR_NEXT,      S_IDLE};
         6'd26: uw = '{MUL_ACC_HI,  AX_Y, WB_NONE,       BR_NEXT,      S_IDLE};
         6'd27: uw = '{MUL_ACC_LO,  AX_Y, WB_TMP,        BR_NEXT,      S_IDLE};
         6'd28: uw = '{MUL_NONE,    AX_Y, WB_VEL,        BR_NEXT,      S_IDLE};
         6'd29: uw = '{MUL_V_DT,    AX_Y, WB_NONE,       BR_NEXT,      S_IDLE};
         6'd30: uw = '{MUL_NONE,    AX_Y, WB_POS,        BR_NEXT,      S_IDLE};
         6'd31: uw = '{MUL_C_REL,   AX_Z, WB_NONE,       BR_NEXT,      S_IDLE};
         6'd32: uw = '{MUL_NONE,    AX_Z, WB_ACC,        BR_NEXT,      S_IDLE};
         6'd33: uw = '{MUL_ACC_HI,  AX_Z, WB_NONE,       BR_NEXT,      S_IDLE};
         6'd34: uw = '{MUL_ACC_LO,  AX_Z, WB_TMP,        BR_NEXT,      S_IDLE};
         6'd35: uw = '{MUL_NONE,    AX_Z, WB_VEL,        BR_NEXT,      S_IDLE};
         6'd36: uw = '{MUL_V_DT,    AX_Z, WB_NONE,       BR_NEXT,      S_IDLE};
         6'd37: uw = '{MUL_NONE,    AX_Z, WB_POS,        BR_NEXT,      S_IDLE};
         6'd38: uw = '{MUL_NONE,    AX_X, WB_RETIRE,     BR_NEXT,      S_IDLE};
         6'd39: uw = '{MUL_NONE,    AX_X, WB_NONE,       BR_DONE,      S_IDLE};
         default: uw = '{MUL_NONE, AX_X, WB_NONE, BR_JUMP, S_IDLE};
      endcase
      return uw;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/bdi_isqrt.sv =====
// Iterative integer square root of a 64-bit radicand, one result bit per cycle.
// Uses no package items; instantiated by bdi_datapath.
`default_nettype none

module bdi_isqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] radicand,
   output logic        busy,
   output logic [31:0] root
);

   logic [63:0] rem_ff, rem_in;
   logic [63:0] res_ff, res_in;
   logic [63:0] bit_ff, bit_in;
   logic        busy_ff, busy_in;
   logic [63:0] trial;

   assign trial = res_ff + bit_ff;

   always_comb begin
      rem_in  = rem_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      busy_in = busy_ff;
      if (start) begin
         rem_in  = radicand;
         res_in  = '0;
         bit_in  = 64'h4000_0000_0000_0000;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_ff >= trial) begin
            rem_in = rem_ff - trial;
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (bit_ff[0]) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
   end

   assign busy = busy_ff;
   assign root = res_ff[31:0];

endmodule

`default_nettype wire

// ===== hw/rtl/bdi_datapath.sv =====
// Datapath: state, configuration registers, shared 33x33 multiplier, writeback.
// Depends on bdi_pkg and bdi_isqrt; driven by the control word from bdi_sequencer.
`default_nettype none

module bdi_datapath #(
   parameter int RANGE_LIMIT = 1400
) (
   input  logic                                clock,
   input  logic                                reset,
   input  bdi_pkg::seq_ctl_type                ctl,
   output bdi_pkg::dp_stat_type                stat,
   input  bdi_pkg::req_type                    req_payload,
   input  logic                                csr_we,
   input  logic [bdi_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [31:0]                         csr_data,
   output bdi_pkg::rsp_type                    rsp_payload
);
   import bdi_pkg::*;

   localparam logic signed [31:0] LIMIT_Q = 32'(RANGE_LIMIT * 65536);
   localparam logic signed [65:0] SAT_HI  = 66'sd2147483647;
   localparam logic signed [65:0] SAT_LO  = -66'sd2147483648;

   function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
      if (x > SAT_HI) begin
         return 32'sh7FFF_FFFF;
      end else if (x < SAT_LO) begin
         return 32'sh8000_0000;
      end
      return x[31:0];
   endfunction

   logic signed [31:0] wind_ff [3], wind_in [3];
   logic signed [31:0] grav_ff [3], grav_in [3];
   logic signed [31:0] drag_ff, drag_in;
   logic [30:0]        muzzle_ff, muzzle_in;

   logic signed [31:0] pos_ff [3], pos_in [3];
   logic signed [31:0] prev_ff [3], prev_in [3];
   logic signed [31:0] vel_ff [3], vel_in [3];
   logic               flying_ff, flying_in;
   logic               retired_ff, retired_in;

   logic signed [31:0] rel_ff [3], rel_in [3];
   logic [63:0]        sumsq_ff, sumsq_in;
   logic signed [31:0] coef_ff, coef_in;
   logic signed [47:0] acc_ff, acc_in;
   logic signed [47:0] tmp_ff, tmp_in;
   logic signed [65:0] mul_ff, mul_in;
   req_type            req_ff;
   rsp_type            rsp_ff;

   logic [1:0]         ax;
   logic signed [31:0] pos_sel, vel_sel, rel_sel, grav_sel, dir_sel;
   logic signed [32:0] mul_a, mul_b, dt_ext;
   logic signed [65:0] mul_sh, acc_full, vel_full, pos_full;
   logic               sqrt_start, sqrt_busy;
   logic [31:0]        root;

   assign ax       = ctl.uw.ax;
   assign pos_sel  = pos_ff[ax];
   assign vel_sel  = vel_ff[ax];
   assign rel_sel  = rel_ff[ax];
   assign grav_sel = grav_ff[ax];
   assign dt_ext   = $signed({17'd0, req_ff.time_step});

   always_comb begin
      case (ctl.uw.ax)
         AX_X:    dir_sel = req_ff.dir_x;
         AX_Y:    dir_sel = req_ff.dir_y;
         default: dir_sel = req_ff.dir_z;
      endcase
   end

   always_comb begin
      case (ctl.uw.mul)
         MUL_DIR_MUZ: begin
            mul_a = 33'(dir_sel);
            mul_b = $signed({2'b0, muzzle_ff});
         end
         MUL_REL_SQ: begin
            mul_a = 33'(rel_sel);
            mul_b = 33'(rel_sel);
         end
         MUL_K_MAG: begin
            mul_a = 33'(drag_ff);
            mul_b = $signed({1'b0, root});
         end
         MUL_C_REL: begin
            mul_a = 33'(coef_ff);
            mul_b = 33'(rel_sel);
         end
         MUL_ACC_HI: begin
            mul_a = 33'($signed(acc_ff[47:16]));
            mul_b = dt_ext;
         end
         MUL_ACC_LO: begin
            mul_a = $signed({17'd0, acc_ff[15:0]});
            mul_b = dt_ext;
         end
         MUL_V_DT: begin
            mul_a = 33'(vel_sel);
            mul_b = dt_ext;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_in   = mul_a * mul_b;
   assign mul_sh   = mul_ff >>> 16;
   assign acc_full = mul_sh + 66'(grav_sel);
   assign vel_full = 66'(vel_sel) + 66'(tmp_ff) + $signed({50'd0, mul_ff[31:16]});
   assign pos_full = 66'(pos_sel) + mul_sh;

   always_comb begin
      wind_in   = wind_ff;
      grav_in   = grav_ff;
      drag_in   = drag_ff;
      muzzle_in = muzzle_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_WIND_X: wind_in[0] = csr_data;
            CSR_WIND_Y: wind_in[1] = csr_data;
            CSR_WIND_Z: wind_in[2] = csr_data;
            CSR_GRAV_X: grav_in[0] = csr_data;
            CSR_GRAV_Y: grav_in[1] = csr_data;
            CSR_GRAV_Z: grav_in[2] = csr_data;
            CSR_DRAG:   drag_in    = csr_data;
            CSR_MUZZLE: muzzle_in  = csr_data[30:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      pos_in     = pos_ff;
      prev_in    = prev_ff;
      vel_in     = vel_ff;
      flying_in  = flying_ff;
      retired_in = ctl.load ? 1'b0 : retired_ff;
      rel_in     = rel_ff;
      sumsq_in   = sumsq_ff;
      coef_in    = coef_ff;
      acc_in     = acc_ff;
      tmp_in     = tmp_ff;
      case (ctl.uw.wb)
         WB_FIRE_POS: begin
            pos_in[0] = req_ff.start_x;
            pos_in[1] = req_ff.start_y;
            pos_in[2] = req_ff.start_z;
            flying_in = 1'b1;
         end
         WB_FIRE_VEL:  vel_in[ax] = sat32(mul_sh);
         WB_HIT: begin
            pos_in    = prev_ff;
            flying_in = 1'b0;
         end
         WB_REL_ALL: begin
            for (int i = 0; i < 3; i++) begin
               rel_in[i] = sat32(66'(vel_ff[i]) - 66'(wind_ff[i]));
            end
            sumsq_in = '0;
         end
         WB_SUMSQ_ADD: sumsq_in = sumsq_ff + mul_ff[63:0];
         WB_COEF:      coef_in = sat32(mul_sh);
         WB_ACC:       acc_in = acc_full[47:0];
         WB_TMP:       tmp_in = mul_ff[47:0];
         WB_VEL:       vel_in[ax] = sat32(vel_full);
         WB_POS: begin
            prev_in[ax] = pos_sel;
            pos_in[ax]  = sat32(pos_full);
         end
         WB_RETIRE: begin
            if (pos_ff[2] > LIMIT_Q) begin
               flying_in  = 1'b0;
               retired_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   assign sqrt_start = (ctl.uw.wb == WB_SQRT_START);

   bdi_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (sumsq_ff),
      .busy     (sqrt_busy),
      .root     (root)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            wind_ff[i] <= '0;
            grav_ff[i] <= '0;
            pos_ff[i]  <= '0;
            prev_ff[i] <= '0;
            vel_ff[i]  <= '0;
         end
         drag_ff    <= '0;
         muzzle_ff  <= '0;
         flying_ff  <= 1'b0;
         retired_ff <= 1'b0;
      end else begin
         wind_ff    <= wind_in;
         grav_ff    <= grav_in;
         drag_ff    <= drag_in;
         muzzle_ff  <= muzzle_in;
         pos_ff     <= pos_in;
         prev_ff    <= prev_in;
         vel_ff     <= vel_in;
         flying_ff  <= flying_in;
         retired_ff <= retired_in;
      end
   end

   always_ff @(posedge clock) begin
      rel_ff   <= rel_in;
      sumsq_ff <= sumsq_in;
      coef_ff  <= coef_in;
      acc_ff   <= acc_in;
      tmp_ff   <= tmp_in;
      if (ctl.uw.mul != MUL_NONE) begin
         mul_ff <= mul_in;
      end
      if (ctl.load) begin
         req_ff <= req_payload;
      end
      if (ctl.emit) begin
         rsp_ff <= '{pos_ff[0], pos_ff[1], pos_ff[2], flying_ff, retired_ff};
      end
   end

   assign stat        = '{flying: flying_ff, sqrt_busy: sqrt_busy};
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/bdi_sequencer.sv =====
// Microcode sequencer: step counter over the bdi_ucode table, branches, handshakes.
// Depends on bdi_pkg; drives bdi_datapath through seq_ctl_type.
`default_nettype none

module bdi_sequencer (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_op,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  bdi_pkg::dp_stat_type stat,
   output bdi_pkg::seq_ctl_type ctl
);
   import bdi_pkg::*;

   step_type  pc_ff, pc_in;
   logic      rsp_valid_ff, rsp_valid_in;
   uword_type uw;
   logic      accept, emit;

   assign uw        = bdi_ucode(pc_ff);
   assign req_ready = (pc_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign emit      = (uw.br == BR_DONE) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      pc_in = pc_ff;
      case (uw.br)
         BR_NEXT: pc_in = pc_ff + 6'd1;
         BR_JUMP: pc_in = uw.target;
         BR_DISPATCH: begin
            if (accept) begin
               case (req_op)
                  OP_FIRE: pc_in = S_FIRE;
                  OP_TICK: pc_in = S_TICK;
                  OP_HIT:  pc_in = S_HIT;
                  default: pc_in = S_END;
               endcase
            end
         end
         BR_SKIP_IDLE: pc_in = stat.flying ? pc_ff + 6'd1 : uw.target;
         BR_WAIT_SQRT: pc_in = stat.sqrt_busy ? pc_ff : pc_ff + 6'd1;
         BR_DONE:      pc_in = emit ? S_IDLE : pc_ff;
         default:      pc_in = S_IDLE;
      endcase
   end

   assign rsp_valid_in = emit || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign ctl       = '{uw: uw, load: accept, emit: emit};

endmodule

`default_nettype wire

// ===== hw/rtl/ballistic_drag_integrator.sv =====
// A tick in flight takes the relative velocity through the 32-step square root and
//   the steps of the shared 33x33 multiplier before the result is ready.
// Fire and hit set the state; an idle tick or unused code skips to the result step.
// One request at a time; the result register lets the next request in while it waits.
// Synchronous active-high reset clears state, configuration and the step counter.
`default_nettype none

module ballistic_drag_integrator #(
   parameter int RANGE_LIMIT = 1400
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  bdi_pkg::req_type              req_payload,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output bdi_pkg::rsp_type              rsp_payload,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [bdi_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                   csr_data
);
   import bdi_pkg::*;

   seq_ctl_type ctl;
   dp_stat_type stat;

   assign csr_ready = 1'b1;

   bdi_sequencer u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_op    (req_payload.operation),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .ctl       (ctl)
   );

   bdi_datapath #(
      .RANGE_LIMIT (RANGE_LIMIT)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .stat        (stat),
      .req_payload (req_payload),
      .csr_we      (csr_valid && csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

// ===== hw/rtl/bdi_checker.sv =====
// Port-level checks for ballistic_drag_integrator, attached by the bind below.
// Depends on bdi_pkg for the result type.
`default_nettype none

module bdi_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input bdi_pkg::rsp_type rsp_payload
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_payload))
      else $error("result changed while stalled");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while previous one still in progress");

   a_retire_lands: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.retired |-> !rsp_payload.flying)
      else $error("retired projectile still flying");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result presented right after reset");

endmodule

bind ballistic_drag_integrator bdi_checker u_bdi_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

`default_nettype wire

// ===== test/tb_ballistic_drag_integrator.sv =====
// Testbench for ballistic_drag_integrator: random and directed fire/tick/hit requests,
// checked against an in-bench fixed-point drag integrator, with stalls on both channels.
// Depends on bdi_pkg and the ballistic_drag_integrator RTL only.
`default_nettype none

module tb_ballistic_drag_integrator;
   timeunit 1ns;
   timeprecision 1ps;

   import bdi_pkg::*;

   localparam int TRAVEL_LIMIT = 1400;
   localparam logic [1:0] OP_SPARE = 2'd3;
   localparam int ITEM_TARGET = 1550;
   localparam int HOLD_CYCLES = 400;
   localparam int QUIET_LIMIT = 5000;
   localparam int FLUSH_CYCLES = 100;

   typedef struct {
      logic [CSR_IDX_W-1:0] idx;
      logic [31:0]          data;
   } setting_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                 req_valid = 1'b0;
   logic                 req_ready;
   req_type              req_payload = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   rsp_type              rsp_payload;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [31:0]          csr_data = '0;

   req_type     shot_queue[$];
   rsp_type     flight_reports[$];
   setting_type setting_queue[$];

   int shots_queued = 0;
   int fault_count = 0;
   int quiet_cycles = 0;
   int hold_left = 0;
   logic hold_trigger = 1'b0;
   int req_idle_pct = 25;
   int rsp_idle_pct = 25;

   logic signed [31:0] proj_pos [3] = '{default: '0};
   logic signed [31:0] proj_prev [3] = '{default: '0};
   logic signed [31:0] proj_vel [3] = '{default: '0};
   bit                 proj_flying = 1'b0;

   logic signed [31:0] wind_set [3] = '{default: '0};
   logic signed [31:0] grav_set [3] = '{default: '0};
   logic signed [31:0] drag_set = '0;
   logic [30:0]        muzzle_set = '0;

   ballistic_drag_integrator #(
      .RANGE_LIMIT(TRAVEL_LIMIT)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_payload(rsp_payload),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic signed [31:0] clamp32(input longint x);
      if (x > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
      if (x < -64'sh8000_0000) return 32'sh8000_0000;
      return x[31:0];
   endfunction

   function automatic logic [63:0] root_floor(input logic [63:0] n);
      logic [63:0] r;
      logic [63:0] t;
      r = '0;
      for (int b = 31; b >= 0; b--) begin
         t = r | (64'd1 << b);
         if (t * t <= n) r = t;
      end
      return r;
   endfunction

   function automatic rsp_type fly_projectile(input req_type rq);
      longint             rel [3];
      longint             dt;
      longint             mag;
      longint             coef;
      longint             acc;
      logic [63:0]        sumsq;
      logic signed [31:0] start [3];
      logic signed [31:0] aim [3];
      rsp_type            rep;
      bit                 retired;
      retired = 1'b0;
      dt = rq.time_step;
      start = '{rq.start_x, rq.start_y, rq.start_z};
      aim = '{rq.dir_x, rq.dir_y, rq.dir_z};
      case (rq.operation)
         OP_FIRE: begin
            for (int i = 0; i < 3; i++) begin
               proj_pos[i] = start[i];
               proj_vel[i] = clamp32((longint'(aim[i]) * longint'(muzzle_set)) >>> 16);
            end
            proj_flying = 1'b1;
         end
         OP_TICK: begin
            if (proj_flying) begin
               sumsq = '0;
               for (int i = 0; i < 3; i++) begin
                  rel[i] = clamp32(longint'(proj_vel[i]) - longint'(wind_set[i]));
                  sumsq = sumsq + 64'(rel[i] * rel[i]);
               end
               mag = root_floor(sumsq);
               coef = clamp32((longint'(drag_set) * mag) >>> 16);
               for (int i = 0; i < 3; i++) begin
                  acc = ((coef * rel[i]) >>> 16) + longint'(grav_set[i]);
                  proj_vel[i] = clamp32(longint'(proj_vel[i]) + ((acc * dt) >>> 16));
               end
               for (int i = 0; i < 3; i++) begin
                  proj_prev[i] = proj_pos[i];
                  proj_pos[i] = clamp32(longint'(proj_pos[i]) +
                                        ((longint'(proj_vel[i]) * dt) >>> 16));
               end
               if (longint'(proj_pos[2]) > longint'(TRAVEL_LIMIT) * 64'sd65536) begin
                  proj_flying = 1'b0;
                  retired = 1'b1;
               end
            end
         end
         OP_HIT: begin
            for (int i = 0; i < 3; i++) proj_pos[i] = proj_prev[i];
            proj_flying = 1'b0;
         end
         default: begin
         end
      endcase
      rep.pos_x = proj_pos[0];
      rep.pos_y = proj_pos[1];
      rep.pos_z = proj_pos[2];
      rep.flying = proj_flying;
      rep.retired = retired;
      return rep;
   endfunction

   // request channel
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            flight_reports.push_back(fly_projectile(req_payload));
         if (!req_valid || req_ready) begin
            if (shot_queue.size() != 0 && $urandom_range(99) >= req_idle_pct) begin
               req_valid <= 1'b1;
               req_payload <= shot_queue.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // register writes
   always @(posedge clock) begin
      setting_type w;
      if (reset) begin
         csr_valid <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_WIND_X: wind_set[0] = csr_data;
               CSR_WIND_Y: wind_set[1] = csr_data;
               CSR_WIND_Z: wind_set[2] = csr_data;
               CSR_GRAV_X: grav_set[0] = csr_data;
               CSR_GRAV_Y: grav_set[1] = csr_data;
               CSR_GRAV_Z: grav_set[2] = csr_data;
               CSR_DRAG:   drag_set = csr_data;
               CSR_MUZZLE: muzzle_set = csr_data[30:0];
               default: begin
               end
            endcase
         end
         if (!csr_valid || csr_ready) begin
            if (setting_queue.size() != 0) begin
               w = setting_queue.pop_front();
               csr_valid <= 1'b1;
               csr_index <= w.idx;
               csr_data <= w.data;
            end else begin
               csr_valid <= 1'b0;
            end
         end
      end
   end

   // response ready, with long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left <= 0;
      end else begin
         if (hold_trigger)
            hold_left <= HOLD_CYCLES;
         else if (hold_left != 0)
            hold_left <= hold_left - 1;
         rsp_ready <= !hold_trigger && hold_left == 0 && $urandom_range(99) >= rsp_idle_pct;
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (flight_reports.size() == 0) begin
            fault_count++;
            if (fault_count <= 10)
               $display("response with no request pending: pos %h %h %h flying %b retired %b",
                        rsp_payload.pos_x, rsp_payload.pos_y, rsp_payload.pos_z,
                        rsp_payload.flying, rsp_payload.retired);
         end else begin
            want = flight_reports.pop_front();
            if (rsp_payload.pos_x !== want.pos_x || rsp_payload.pos_y !== want.pos_y ||
                rsp_payload.pos_z !== want.pos_z || rsp_payload.flying !== want.flying ||
                rsp_payload.retired !== want.retired) begin
               fault_count++;
               if (fault_count <= 10)
                  $display("mismatch at %0t: got pos %h %h %h fly %b ret %b, want %h %h %h %b %b",
                           $realtime, rsp_payload.pos_x, rsp_payload.pos_y,
                           rsp_payload.pos_z, rsp_payload.flying, rsp_payload.retired,
                           want.pos_x, want.pos_y, want.pos_z, want.flying, want.retired);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic [31:0] spread(input int bits);
      logic [31:0] v;
      v = $urandom;
      if (bits < 32) begin
         v = v & ((32'd1 << bits) - 32'd1);
         if ($urandom_range(1) == 1) v = -v;
      end
      return v;
   endfunction

   task automatic add_shot(input logic [1:0] op, input logic [31:0] sx, input logic [31:0] sy,
                           input logic [31:0] sz, input logic [31:0] dx, input logic [31:0] dy,
                           input logic [31:0] dz, input logic [15:0] dt);
      req_type rq;
      rq.operation = op;
      rq.start_x = sx;
      rq.start_y = sy;
      rq.start_z = sz;
      rq.dir_x = dx;
      rq.dir_y = dy;
      rq.dir_z = dz;
      rq.time_step = dt;
      shot_queue.push_back(rq);
      if (op != OP_SPARE) shots_queued++;
   endtask

   task automatic queue_flight();
      int          ticks;
      logic [31:0] sz;
      logic [31:0] dz;
      logic [15:0] dt;
      ticks = $urandom_range(1, 30);
      sz = ($urandom_range(9) == 0) ? $urandom : spread(26);
      dz = ($urandom_range(9) == 0) ? $urandom : 32'($urandom_range(0, 131072));
      add_shot(OP_FIRE, spread(24), spread(24), sz, spread(17), spread(17), dz,
               16'($urandom));
      for (int i = 0; i < ticks; i++) begin
         if ($urandom_range(19) == 0)
            add_shot(OP_SPARE, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                     16'($urandom));
         dt = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 16384));
         add_shot(OP_TICK, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, dt);
      end
      if ($urandom_range(2) == 0)
         add_shot(OP_HIT, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  16'($urandom));
   endtask

   task automatic settle();
      while (shot_queue.size() != 0 || req_valid || flight_reports.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_settings(input logic [31:0] wx, input logic [31:0] wy,
                                 input logic [31:0] wz, input logic [31:0] gx,
                                 input logic [31:0] gy, input logic [31:0] gz,
                                 input logic [31:0] drag, input logic [31:0] muzzle);
      setting_queue.push_back('{CSR_WIND_X, wx});
      setting_queue.push_back('{CSR_WIND_Y, wy});
      setting_queue.push_back('{CSR_WIND_Z, wz});
      setting_queue.push_back('{CSR_GRAV_X, gx});
      setting_queue.push_back('{CSR_GRAV_Y, gy});
      setting_queue.push_back('{CSR_GRAV_Z, gz});
      setting_queue.push_back('{CSR_DRAG, drag});
      setting_queue.push_back('{CSR_MUZZLE, muzzle});
      do @(negedge clock); while (setting_queue.size() != 0 || csr_valid);
   endtask

   initial begin
      int ph;
      int goal;
      int n;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset configuration: idle operations, fire with zero muzzle speed
      add_shot(OP_TICK, 0, 0, 0, 0, 0, 0, 16'hFFFF);
      add_shot(OP_HIT, 0, 0, 0, 0, 0, 0, 16'h0000);
      add_shot(OP_SPARE, 0, 0, 0, 0, 0, 0, 16'h0000);
      add_shot(OP_FIRE, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
               32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 16'h0000);
      add_shot(OP_TICK, 0, 0, 0, 0, 0, 0, 16'h8000);
      settle();

      write_settings(32'h0001_0000, 32'h0, -32'sd32768, 32'h0, -32'sd642253, 32'h0,
                     32'd66, 32'h00C8_0000);
      add_shot(OP_FIRE, 0, 0, 0, 0, 0, 32'h0001_0000, 16'h0000);
      add_shot(OP_TICK, 0, 0, 0, 0, 0, 0, 16'h4000);
      add_shot(OP_TICK, 0, 0, 0, 0, 0, 0, 16'h0000);
      add_shot(OP_TICK, 0, 0, 0, 0, 0, 0, 16'hFFFF);
      add_shot(OP_SPARE, 0, 0, 0, 0, 0, 0, 16'h0000);
      add_shot(OP_HIT, 0, 0, 0, 0, 0, 0, 16'h0000);
      add_shot(OP_HIT, 0, 0, 0, 0, 0, 0, 16'h0000);
      add_shot(OP_TICK, 0, 0, 0, 0, 0, 0, 16'h4000);
      add_shot(OP_FIRE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
               32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h0000);
      add_shot(OP_TICK, 0, 0, 0, 0, 0, 0, 16'hFFFF);
      add_shot(OP_FIRE, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
               32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'h0000);
      add_shot(OP_TICK, 0, 0, 0, 0, 0, 0, 16'hFFFF);
      add_shot(OP_FIRE, 0, 0, 32'h0578_0000 - 32'd1, 0, 0, 32'h0001_0000, 16'h0000);
      add_shot(OP_TICK, 0, 0, 0, 0, 0, 0, 16'h0100);
      add_shot(OP_TICK, 0, 0, 0, 0, 0, 0, 16'h0100);
      add_shot(OP_HIT, 0, 0, 0, 0, 0, 0, 16'h0000);
      add_shot(OP_FIRE, 0, 0, 32'h0578_0000, 0, 0, 0, 16'h0000);
      add_shot(OP_TICK, 0, 0, 0, 0, 0, 0, 16'h0000);
      add_shot(OP_SPARE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
               32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
      add_shot(OP_FIRE, 32'h0010_0000, 32'h0020_0000, 32'h0100_0000,
               -32'sd65536, 32'h0000_8000, -32'sd65536, 16'h0000);
      add_shot(OP_TICK, 0, 0, 0, 0, 0, 0, 16'h2000);

      ph = 0;
      while (shots_queued < ITEM_TARGET) begin
         settle();
         case (ph % 5)
            0: write_settings(spread(18), spread(18), spread(18), spread(16),
                              -32'sd642253 + spread(14), spread(16),
                              32'($urandom_range(0, 2000)),
                              32'($urandom_range(20, 400)) << 16);
            1: write_settings($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                              $urandom, $urandom);
            2: write_settings(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                              32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
            3: write_settings(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                              32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
            default: write_settings(spread(22), spread(22), spread(22), spread(17),
                                    spread(20), spread(17),
                                    -32'($urandom_range(0, 5000)),
                                    32'($urandom_range(1, 1000)) << 16);
         endcase
         req_idle_pct <= (ph == 5) ? 0 : 25;
         rsp_idle_pct <= (ph == 5) ? 0 : 25;
         goal = shots_queued + 150;
         while (shots_queued < goal) begin
            if ($urandom_range(99) < 85) begin
               queue_flight();
            end else begin
               n = $urandom_range(1, 3);
               repeat (n)
                  add_shot(2'($urandom_range(3)), $urandom, $urandom, $urandom, $urandom,
                           $urandom, $urandom, 16'($urandom));
            end
         end
         if (ph == 1) begin
            hold_trigger <= 1'b1;
            @(negedge clock);
            hold_trigger <= 1'b0;
         end
         ph++;
      end

      settle();
      repeat (FLUSH_CYCLES) @(negedge clock);
      if (fault_count == 0 && flight_reports.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

`default_nettype wire
